// ===== rtl/core/asq_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm sensor qualifier package
// Shared types, register indexes and reset values for the sensor qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package asq_pkg;

   localparam int TIME_W = 32;
   localparam int THR_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int LEVELS_W = 4;
   localparam int ENABLE_W = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_FIRE_CONFIRM    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRE_CLEAR      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RAIN_CONFIRM    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RAIN_CLEAR      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_IMPACT_COOLDOWN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IMPACT_HOLD     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_LEVELS   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE_MASK     = 3'd7;

   // Reset values of the registers.
   localparam logic [THR_W-1:0]    RST_FIRE_CONFIRM    = 16'd2000;
   localparam logic [THR_W-1:0]    RST_FIRE_CLEAR      = 16'd5000;
   localparam logic [THR_W-1:0]    RST_RAIN_CONFIRM    = 16'd3000;
   localparam logic [THR_W-1:0]    RST_RAIN_CLEAR      = 16'd10000;
   localparam logic [THR_W-1:0]    RST_IMPACT_COOLDOWN = 16'd1000;
   localparam logic [THR_W-1:0]    RST_IMPACT_HOLD     = 16'd5000;
   localparam logic [LEVELS_W-1:0] RST_ACTIVE_LEVELS   = 4'd0;
   localparam logic [ENABLE_W-1:0] RST_ENABLE_MASK     = 3'd7;

   // Bit positions in the polarity and enable registers.
   localparam int LVL_FLAME = 0;
   localparam int LVL_RAIN  = 1;
   localparam int LVL_VIB   = 2;
   localparam int LVL_FAN   = 3;
   localparam int EN_FIRE   = 0;
   localparam int EN_RAIN   = 1;
   localparam int EN_IMPACT = 2;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              flame_pin;
      logic              rain_pin;
      logic              vibration_pin;
      logic              player_busy;
   } asq_req_type;

   typedef struct packed {
      logic fire_alarm;
      logic fan_level;
      logic rain_alert;
      logic impact_alert;
      logic play_alarm;
      logic stop_all;
      logic play_single;
   } asq_rsp_type;

   // Status of one debounced level for the word being processed.
   typedef struct packed {
      logic on;       // alert state after this word
      logic raised;   // alert went on with this word
      logic cleared;  // alert went off with this word
   } asq_deb_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/asq_chan_if.sv =====
// ----------------------------------------------------------------------------
// Alarm sensor qualifier channel
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface asq_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/alarm_sensor_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// Alarm sensor qualifier
// Debounces flame, rain and vibration pins per poll tick and issues alert
// player requests.
// ----------------------------------------------------------------------------
// Each request word is one poll tick: a wrapping millisecond timestamp, the
// raw flame, rain and vibration pin levels and the alert player's busy flag.
// Every request word produces exactly one response word. The block takes one
// word per clock cycle as long as the response side does not stall. A word
// taken at a rising edge is held in the input register until it can move on;
// then the qualification logic, a single pass of subtract-and-compare,
// loads the response register, from which the response word is offered
// to the response channel and held there until the response side takes it.
// A stall on the response side holds the input register, so the request side
// keeps taking words for as long as the input register can move on. Flame and
// rain are mapped through their polarity bits and must hold steady for their
// confirm or clear time, measured as the modulo 2^32 difference between the
// tick timestamp and the last raw change. An impact is an active rising edge
// of the vibration pin outside the cooldown; it holds the impact flag for the
// hold time and asks for a single tone unless the fire alarm is on. A
// disabled function freezes its state and makes no requests. Configuration
// registers are to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_sensor_qualifier_top
   import asq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   asq_chan_if.sink                    req_chan,
   asq_chan_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [THR_W-1:0]    fire_confirm_ff, fire_clear_ff;
   logic [THR_W-1:0]    rain_confirm_ff, rain_clear_ff;
   logic [THR_W-1:0]    impact_cooldown_ff, impact_hold_ff;
   logic [LEVELS_W-1:0] active_levels_ff;
   logic [ENABLE_W-1:0] enable_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fire_confirm_ff    <= RST_FIRE_CONFIRM;
         fire_clear_ff      <= RST_FIRE_CLEAR;
         rain_confirm_ff    <= RST_RAIN_CONFIRM;
         rain_clear_ff      <= RST_RAIN_CLEAR;
         impact_cooldown_ff <= RST_IMPACT_COOLDOWN;
         impact_hold_ff     <= RST_IMPACT_HOLD;
         active_levels_ff   <= RST_ACTIVE_LEVELS;
         enable_mask_ff     <= RST_ENABLE_MASK;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FIRE_CONFIRM:    fire_confirm_ff    <= csr_wdata;
            REG_FIRE_CLEAR:      fire_clear_ff      <= csr_wdata;
            REG_RAIN_CONFIRM:    rain_confirm_ff    <= csr_wdata;
            REG_RAIN_CLEAR:      rain_clear_ff      <= csr_wdata;
            REG_IMPACT_COOLDOWN: impact_cooldown_ff <= csr_wdata;
            REG_IMPACT_HOLD:     impact_hold_ff     <= csr_wdata;
            REG_ACTIVE_LEVELS:   active_levels_ff   <= csr_wdata[LEVELS_W-1:0];
            REG_ENABLE_MASK:     enable_mask_ff     <= csr_wdata[ENABLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline control. The input register moves on whenever the response
   // register is empty or is being emptied in this cycle.
   logic        s1_valid_ff;
   asq_req_type s1_data_ff;
   logic        rsp_valid_ff;
   asq_rsp_type rsp_data_ff, rsp_data_in;
   logic        advance;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.data;
      end
   end

   // Flame and rain qualification. A pin is active when it matches its
   // polarity bit.
   logic               flame, rain;
   asq_deb_status_type fire_status, rain_status;

   assign flame = (s1_data_ff.flame_pin == active_levels_ff[LVL_FLAME]);
   assign rain  = (s1_data_ff.rain_pin == active_levels_ff[LVL_RAIN]);

   asq_debounce u_fire_deb (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .enable     (enable_mask_ff[EN_FIRE]),
      .level      (flame),
      .now_ms     (s1_data_ff.now_ms),
      .confirm_ms (fire_confirm_ff),
      .clear_ms   (fire_clear_ff),
      .status     (fire_status)
   );

   asq_debounce u_rain_deb (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .enable     (enable_mask_ff[EN_RAIN]),
      .level      (rain),
      .now_ms     (s1_data_ff.now_ms),
      .confirm_ms (rain_confirm_ff),
      .clear_ms   (rain_clear_ff),
      .status     (rain_status)
   );

   // Impact detection. The hold time is checked against the impact time as
   // it stands after this word, so a zero hold time clears the flag at once.
   logic              vib_last_ff, vib_last_in;
   logic [TIME_W-1:0] impact_time_ff, impact_time_in;
   logic              impact_on_ff, impact_on_in;
   logic              vib, impact_accept, impact_en;
   logic [TIME_W-1:0] since_impact, held_for;

   always_comb begin
      impact_en      = enable_mask_ff[EN_IMPACT];
      vib            = (s1_data_ff.vibration_pin == active_levels_ff[LVL_VIB]);
      since_impact   = s1_data_ff.now_ms - impact_time_ff;
      impact_accept  = vib && !vib_last_ff &&
                       (since_impact >= {{(TIME_W-THR_W){1'b0}}, impact_cooldown_ff});
      impact_time_in = impact_accept ? s1_data_ff.now_ms : impact_time_ff;
      held_for       = s1_data_ff.now_ms - impact_time_in;
      vib_last_in    = vib;
      impact_on_in   = (impact_accept || impact_on_ff) &&
                       !(held_for >= {{(TIME_W-THR_W){1'b0}}, impact_hold_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vib_last_ff    <= 1'b0;
         impact_time_ff <= '0;
         impact_on_ff   <= 1'b0;
      end else if (advance && impact_en) begin
         vib_last_ff    <= vib_last_in;
         impact_time_ff <= impact_time_in;
         impact_on_ff   <= impact_on_in;
      end
   end

   // Response word. The fire requests only come from an enabled fire
   // function; the single tone is suppressed while the fire alarm is on.
   always_comb begin
      rsp_data_in.fire_alarm   = fire_status.on;
      rsp_data_in.fan_level    = (fire_status.on == active_levels_ff[LVL_FAN]);
      rsp_data_in.rain_alert   = rain_status.on;
      rsp_data_in.impact_alert = impact_en ? impact_on_in : impact_on_ff;
      rsp_data_in.play_alarm   = enable_mask_ff[EN_FIRE] &&
                                 (fire_status.raised ||
                                  (fire_status.on && !s1_data_ff.player_busy));
      rsp_data_in.stop_all     = fire_status.cleared && s1_data_ff.player_busy;
      rsp_data_in.play_single  = impact_en && impact_accept && !fire_status.on;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/asq_debounce.sv =====
// ----------------------------------------------------------------------------
// Asymmetric level debouncer
// Tracks the time of the last level change and raises or clears an alert once
// the level has held for the confirm or clear time.
// ----------------------------------------------------------------------------
`default_nettype none

module asq_debounce
   import asq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              enable,
   input  wire logic              level,
   input  wire logic [TIME_W-1:0] now_ms,
   input  wire logic [THR_W-1:0]  confirm_ms,
   input  wire logic [THR_W-1:0]  clear_ms,
   output asq_deb_status_type     status
);

   logic              last_ff, last_in;
   logic [TIME_W-1:0] since_ff, since_in;
   logic              on_ff, on_in;
   logic [TIME_W-1:0] stable;
   logic              raise, clear;

   // A change of level restarts the stable time with this word's timestamp.
   always_comb begin
      last_in  = level;
      since_in = (level != last_ff) ? now_ms : since_ff;
      stable   = now_ms - since_in;
      raise    = !on_ff && level && (stable >= {{(TIME_W-THR_W){1'b0}}, confirm_ms});
      clear    = on_ff && !level && (stable >= {{(TIME_W-THR_W){1'b0}}, clear_ms});
      if (raise) begin
         on_in = 1'b1;
      end else if (clear) begin
         on_in = 1'b0;
      end else begin
         on_in = on_ff;
      end
      status.on      = enable ? on_in : on_ff;
      status.raised  = enable && raise;
      status.cleared = enable && clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= 1'b0;
         since_ff <= '0;
         on_ff    <= 1'b0;
      end else if (advance && enable) begin
         last_ff  <= last_in;
         since_ff <= since_in;
         on_ff    <= on_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/asq_alert_checker.sv =====
// ----------------------------------------------------------------------------
// Alarm sensor qualifier checker
// Follows the request, response and register ports of the qualifier, works
// out the response word due for every accepted poll tick and compares each
// response word, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module asq_alert_checker
   import asq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire asq_req_type            req_word,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire asq_rsp_type            rsp_word,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          fail_count,
   output int                          words_pending,
   output int                          words_checked,
   output int                          fire_raises,
   output int                          rain_raises,
   output int                          stop_requests,
   output int                          tone_requests
);

   localparam int PRINT_LIMIT = 40;

   // Shadow copy of the register file.
   logic [THR_W-1:0]    cfg_fire_confirm, cfg_fire_clear;
   logic [THR_W-1:0]    cfg_rain_confirm, cfg_rain_clear;
   logic [THR_W-1:0]    cfg_cooldown, cfg_hold;
   logic [LEVELS_W-1:0] cfg_levels;
   logic [ENABLE_W-1:0] cfg_enable;

   // Debounce and impact state as it stands after the last accepted tick.
   logic              flame_seen, fire_state, rain_seen, rain_state;
   logic              shake_seen, impact_state;
   logic [TIME_W-1:0] flame_mark, rain_mark, impact_mark;

   asq_rsp_type pending_responses[$];

   task automatic report_fault(input string msg);
      if (fail_count < PRINT_LIMIT)
         $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic got, input logic want);
      if (got !== want)
         report_fault($sformatf("response %0d field %s is %b, should be %b",
                                words_checked, name, got, want));
   endtask

   // Qualifies one poll tick and advances the shadow state.
   function automatic asq_rsp_type qualify_tick(input asq_req_type tick);
      asq_rsp_type       r;
      logic              flame, rain, shake;
      logic [TIME_W-1:0] held;
      r = '0;
      if (cfg_enable[EN_FIRE]) begin
         flame = (tick.flame_pin == cfg_levels[LVL_FLAME]);
         if (flame != flame_seen) begin
            flame_seen = flame;
            flame_mark = tick.now_ms;
         end
         held = tick.now_ms - flame_mark;
         if (!fire_state && flame && held >= TIME_W'(cfg_fire_confirm)) begin
            fire_state   = 1'b1;
            r.play_alarm = 1'b1;
            fire_raises++;
         end else if (fire_state && !flame && held >= TIME_W'(cfg_fire_clear)) begin
            fire_state = 1'b0;
            r.stop_all = tick.player_busy;
         end
         if (fire_state && !tick.player_busy)
            r.play_alarm = 1'b1;
      end
      if (cfg_enable[EN_RAIN]) begin
         rain = (tick.rain_pin == cfg_levels[LVL_RAIN]);
         if (rain != rain_seen) begin
            rain_seen = rain;
            rain_mark = tick.now_ms;
         end
         held = tick.now_ms - rain_mark;
         if (!rain_state && rain && held >= TIME_W'(cfg_rain_confirm)) begin
            rain_state = 1'b1;
            rain_raises++;
         end else if (rain_state && !rain && held >= TIME_W'(cfg_rain_clear)) begin
            rain_state = 1'b0;
         end
      end
      if (cfg_enable[EN_IMPACT]) begin
         shake = (tick.vibration_pin == cfg_levels[LVL_VIB]);
         held  = tick.now_ms - impact_mark;
         if (shake && !shake_seen && held >= TIME_W'(cfg_cooldown)) begin
            impact_mark   = tick.now_ms;
            impact_state  = 1'b1;
            r.play_single = !fire_state;
         end
         shake_seen = shake;
         held       = tick.now_ms - impact_mark;
         if (impact_state && held >= TIME_W'(cfg_hold))
            impact_state = 1'b0;
      end
      r.fire_alarm   = fire_state;
      r.fan_level    = (fire_state == cfg_levels[LVL_FAN]);
      r.rain_alert   = rain_state;
      r.impact_alert = impact_state;
      return r;
   endfunction

   always @(posedge clock) begin : follow
      asq_rsp_type want;
      if (reset) begin
         cfg_fire_confirm = RST_FIRE_CONFIRM;
         cfg_fire_clear   = RST_FIRE_CLEAR;
         cfg_rain_confirm = RST_RAIN_CONFIRM;
         cfg_rain_clear   = RST_RAIN_CLEAR;
         cfg_cooldown     = RST_IMPACT_COOLDOWN;
         cfg_hold         = RST_IMPACT_HOLD;
         cfg_levels       = RST_ACTIVE_LEVELS;
         cfg_enable       = RST_ENABLE_MASK;
         flame_seen   = 1'b0;
         fire_state   = 1'b0;
         rain_seen    = 1'b0;
         rain_state   = 1'b0;
         shake_seen   = 1'b0;
         impact_state = 1'b0;
         flame_mark   = '0;
         rain_mark    = '0;
         impact_mark  = '0;
         pending_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               report_fault($sformatf("response word %h arrived with none awaited",
                                      rsp_word));
            end else begin
               want = pending_responses.pop_front();
               check_field("fire_alarm",   rsp_word.fire_alarm,   want.fire_alarm);
               check_field("fan_level",    rsp_word.fan_level,    want.fan_level);
               check_field("rain_alert",   rsp_word.rain_alert,   want.rain_alert);
               check_field("impact_alert", rsp_word.impact_alert, want.impact_alert);
               check_field("play_alarm",   rsp_word.play_alarm,   want.play_alarm);
               check_field("stop_all",     rsp_word.stop_all,     want.stop_all);
               check_field("play_single",  rsp_word.play_single,  want.play_single);
               words_checked++;
            end
         end
         if (req_valid && req_ready) begin
            want = qualify_tick(req_word);
            pending_responses.push_back(want);
            if (want.stop_all)
               stop_requests++;
            if (want.play_single)
               tone_requests++;
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_FIRE_CONFIRM:    cfg_fire_confirm = csr_wdata;
               REG_FIRE_CLEAR:      cfg_fire_clear   = csr_wdata;
               REG_RAIN_CONFIRM:    cfg_rain_confirm = csr_wdata;
               REG_RAIN_CLEAR:      cfg_rain_clear   = csr_wdata;
               REG_IMPACT_COOLDOWN: cfg_cooldown     = csr_wdata;
               REG_IMPACT_HOLD:     cfg_hold         = csr_wdata;
               REG_ACTIVE_LEVELS:   cfg_levels       = csr_wdata[LEVELS_W-1:0];
               REG_ENABLE_MASK:     cfg_enable       = csr_wdata[ENABLE_W-1:0];
               default: ;
            endcase
         end
      end
      words_pending = pending_responses.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_alarm_sensor_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// Alarm sensor qualifier testbench
// Drives poll ticks and register settings into the qualifier, lets the
// checker beside it judge every response word, and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_alarm_sensor_qualifier_top;
   import asq_pkg::*;

   // Chance in a hundred that either side holds back in a given cycle.
   localparam int IDLE_PCT     = 37;
   // Cycles without any word moving before the run is declared hung. A
   // correct run keeps words moving well inside this limit, even across a
   // full register update.
   localparam int STALL_LIMIT  = 2000;
   // The block offers each response from its response register; the run waits
   // on at the end so that any stray response word is still caught.
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 8;
   localparam int PHASE_TICKS  = 166;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // When set, neither side ever holds back.
   logic calm = 1'b0;

   int quiet_cycles  = 0;
   int ticks_sent    = 0;
   int settings_used = 0;

   int fail_count, words_pending, words_checked;
   int fire_raises, rain_raises, stop_requests, tone_requests;

   asq_chan_if #(.payload_type(asq_req_type)) req_chan ();
   asq_chan_if #(.payload_type(asq_rsp_type)) rsp_chan ();

   alarm_sensor_qualifier_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   asq_alert_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_word      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_word      (rsp_chan.data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked),
      .fire_raises   (fire_raises),
      .rain_raises   (rain_raises),
      .stop_requests (stop_requests),
      .tone_requests (tone_requests)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The response side stalls at random, except during the calm stretch.
   // Like every other input it changes on the falling edge only.
   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one poll tick and returns on the falling edge after it has been
   // taken. The valid line is left high on return so that a following word
   // can go straight out without a gap; whoever comes next decides.
   task automatic send_tick(input logic [TIME_W-1:0] now, input logic flame, rain, vib,
                            busy);
      asq_req_type word;
      word.now_ms        = now;
      word.flame_pin     = flame;
      word.rain_pin      = rain;
      word.vibration_pin = vib;
      word.player_busy   = busy;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= word;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      ticks_sent++;
   endtask

   // Withdraws the request side and waits until every awaited response word
   // has come back, which leaves the block idle.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0)
         @(negedge clock);
   endtask

   // One register write; the caller lowers the write enable afterwards.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic program_registers(input logic [THR_W-1:0] fire_on_ms, fire_off_ms,
                                    rain_on_ms, rain_off_ms, cooldown_ms, hold_ms,
                                    input logic [LEVELS_W-1:0] levels,
                                    input logic [ENABLE_W-1:0] enables);
      write_reg(REG_FIRE_CONFIRM, fire_on_ms);
      write_reg(REG_FIRE_CLEAR, fire_off_ms);
      write_reg(REG_RAIN_CONFIRM, rain_on_ms);
      write_reg(REG_RAIN_CLEAR, rain_off_ms);
      write_reg(REG_IMPACT_COOLDOWN, cooldown_ms);
      write_reg(REG_IMPACT_HOLD, hold_ms);
      write_reg(REG_ACTIVE_LEVELS, CSR_DATA_W'(levels));
      write_reg(REG_ENABLE_MASK, CSR_DATA_W'(enables));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Thresholds lean towards short times so that alarms actually change,
   // with both extremes turning up now and then.
   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5: return THR_W'($urandom_range(1, 64));
         default: return THR_W'($urandom_range(65, 65535));
      endcase
   endfunction

   // One random phase under a fresh register setting. Timestamps mostly
   // creep forward in steps scaled to the thresholds so that levels can be
   // held long enough to qualify; now and then they jump anywhere or land
   // just short of the wrap. Pins mostly toggle one at a time, with some
   // words of pure noise mixed in.
   task automatic run_phase(input int sel, input int count);
      logic [THR_W-1:0]    thr [6];
      logic [LEVELS_W-1:0] levels;
      logic [ENABLE_W-1:0] enables;
      logic [TIME_W-1:0]   now;
      logic                flame, rain, vib;
      int unsigned         step_max;
      int                  k;
      int                  roll;
      case (sel)
         0: begin
            // Every time met at once.
            for (k = 0; k < 6; k++)
               thr[k] = '0;
            levels  = LEVELS_W'($urandom_range(0, 15));
            enables = RST_ENABLE_MASK;
         end
         1: begin
            // Longest times, every pin and the fan active high.
            for (k = 0; k < 6; k++)
               thr[k] = '1;
            levels  = '1;
            enables = RST_ENABLE_MASK;
         end
         2: begin
            thr[0]  = RST_FIRE_CONFIRM;
            thr[1]  = RST_FIRE_CLEAR;
            thr[2]  = RST_RAIN_CONFIRM;
            thr[3]  = RST_RAIN_CLEAR;
            thr[4]  = RST_IMPACT_COOLDOWN;
            thr[5]  = RST_IMPACT_HOLD;
            levels  = RST_ACTIVE_LEVELS;
            enables = RST_ENABLE_MASK;
         end
         default: begin
            for (k = 0; k < 6; k++)
               thr[k] = pick_threshold();
            levels = LEVELS_W'($urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0)
               enables = ENABLE_W'($urandom_range(0, 7));
            else
               enables = RST_ENABLE_MASK;
         end
      endcase
      step_max = 3;
      for (k = 0; k < 6; k++)
         if (thr[k] / 3 + 2 > step_max)
            step_max = thr[k] / 3 + 2;

      settle();
      program_registers(thr[0], thr[1], thr[2], thr[3], thr[4], thr[5], levels, enables);

      // The reset-value phase runs without any idling on either side.
      calm  = (sel == 2);
      now   = $urandom;
      flame = 1'($urandom_range(0, 1));
      rain  = 1'($urandom_range(0, 1));
      vib   = 1'($urandom_range(0, 1));
      for (k = 0; k < count; k++) begin
         // Halfway through one phase the sender waits for the block to drain.
         if (sel == 3 && k == count / 2)
            settle();
         roll = $urandom_range(0, 99);
         if (roll < 60)
            now += $urandom_range(0, step_max);
         else if (roll < 90)
            now += $urandom_range(0, 3);
         else if (roll < 97)
            now = $urandom;
         else
            now = 32'hFFFF_FFFF - $urandom_range(0, step_max);
         if ($urandom_range(0, 9) == 0) begin
            flame = 1'($urandom_range(0, 1));
            rain  = 1'($urandom_range(0, 1));
            vib   = 1'($urandom_range(0, 1));
         end else begin
            if ($urandom_range(0, 7) == 0)
               flame = !flame;
            if ($urandom_range(0, 7) == 0)
               rain = !rain;
            if ($urandom_range(0, 2) == 0)
               vib = !vib;
         end
         send_tick(now, flame, rain, vib, 1'($urandom_range(0, 1)));
      end
      calm = 1'b0;
   endtask

   initial begin : stimulus
      int p;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;

      // Synchronous reset held from time zero, then released once on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Short times, every pin and the fan active high.
      program_registers(16'd5, 16'd3, 16'd4, 16'd2, 16'd3, 16'd4, 4'hF, RST_ENABLE_MASK);
      send_tick(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      // Impact outside the cooldown with no fire: a single tone is asked for.
      send_tick(32'd10, 1'b1, 1'b0, 1'b1, 1'b0);
      send_tick(32'd12, 1'b1, 1'b1, 1'b0, 1'b0);
      // Fire rises on the same tick as a second impact, so no tone this time.
      send_tick(32'd15, 1'b1, 1'b1, 1'b1, 1'b0);
      send_tick(32'd16, 1'b1, 1'b1, 1'b0, 1'b1);
      send_tick(32'd17, 1'b0, 1'b0, 1'b0, 1'b1);
      // Impact flag expires and the rain alert clears.
      send_tick(32'd19, 1'b0, 1'b0, 1'b0, 1'b1);
      // Fire clears while the player is busy: stop requested.
      send_tick(32'd20, 1'b0, 1'b0, 1'b0, 1'b1);
      // Timestamps across the wrap, and an impact inside the cooldown.
      send_tick(32'hFFFF_FFFE, 1'b1, 1'b1, 1'b1, 1'b0);
      send_tick(32'h0000_0003, 1'b1, 1'b1, 1'b0, 1'b0);
      send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0);
      send_tick(32'h8000_0003, 1'b0, 1'b0, 1'b0, 1'b0);

      // Zero times, everything active low, every function disabled: the
      // flags must hold whatever they had.
      settle();
      program_registers('0, '0, '0, '0, '0, '0, '0, '0);
      send_tick(32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b1);
      send_tick(32'h1234_5679, 1'b1, 1'b1, 1'b1, 1'b0);

      // Enabled again with zero times: alarms change on the very tick, and
      // an impact with no hold time is gone again at once.
      settle();
      write_reg(REG_ENABLE_MASK, CSR_DATA_W'(RST_ENABLE_MASK));
      csr_wr_en <= 1'b0;
      send_tick(32'h1234_567A, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(32'h1234_567A, 1'b1, 1'b1, 1'b1, 1'b1);
      send_tick(32'h1234_567B, 1'b1, 1'b1, 1'b0, 1'b0);
      send_tick(32'h1234_567B, 1'b0, 1'b1, 1'b1, 1'b0);

      // Only the rain function left on, with mixed polarities.
      settle();
      write_reg(REG_ACTIVE_LEVELS, CSR_DATA_W'(4'b1010));
      write_reg(REG_ENABLE_MASK, CSR_DATA_W'(1 << EN_RAIN));
      csr_wr_en <= 1'b0;
      send_tick(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);

      // Random part, one register setting per phase.
      for (p = 0; p < PHASES; p++)
         run_phase(p, PHASE_TICKS);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d poll ticks under %0d register settings; %0d responses compared.",
               ticks_sent, settings_used, words_checked);
      $display("Fire raised %0d times, rain raised %0d times, %0d stops, %0d impact tones.",
               fire_raises, rain_raises, stop_requests, tone_requests);
      if (fail_count == 0 && words_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
